FILE: hdl/isrt_pkg.sv
`timescale 1ns / 1ps

package isrt_pkg;

   localparam int DATA_W = 32;

   // Sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SHIFT = 4'b0010,
      ST_PLACE = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

endpackage

FILE: hdl/insertion_sorter.sv
// Insertion writes a word into an empty list at once and drops it if the list is full; otherwise
// each greater entry is moved up a place in turn, over the store's one read and one write port.
// Once the last word is placed or dropped, words are read from the store into the output register,
// one word per cycle unless rsp_ready stalls; input waits until the final word is in that register.
// Reset (synchronous, active high) empties the list and clears the overflow flag and output valid;
// the store and output data are left as they are, and the store is never read before being written.
`timescale 1ns / 1ps

module insertion_sorter #(
   parameter int MAX_ELEMENTS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [isrt_pkg::DATA_W-1:0] req_value,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [isrt_pkg::DATA_W-1:0] rsp_sorted_value,
   output logic                              rsp_end_of_list,
   output logic                              rsp_overflowed
);

   import isrt_pkg::*;

   localparam int AW = $clog2(MAX_ELEMENTS);
   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);

   logic signed [DATA_W-1:0] store_ff [MAX_ELEMENTS];

   state_type                state_ff, state_in;
   logic [CW-1:0]            fill_ff, fill_in;
   logic                     ovf_ff, ovf_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic                     last_ff, last_in;
   logic [AW-1:0]            hole_ff, hole_in;
   logic [CW-1:0]            rd_idx_ff, rd_idx_in;
   logic                     avail_ff, avail_in;
   logic signed [DATA_W-1:0] rd_data_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic                     rsp_eol_ff, rsp_eol_in;
   logic                     rsp_ovf_ff, rsp_ovf_in;

   logic                     wr_en, rd_en;
   logic [AW-1:0]            wr_addr, rd_addr;
   logic signed [DATA_W-1:0] wr_data;
   logic                     out_free, load, issue;

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_end_of_list  = rsp_eol_ff;
   assign rsp_overflowed   = rsp_ovf_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign load     = (state_ff == ST_EMIT) && avail_ff && out_free;
   assign issue    = (state_ff == ST_EMIT) && (rd_idx_ff < fill_ff) && (!avail_ff || load);

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      ovf_in       = ovf_ff;
      val_in       = val_ff;
      last_in      = last_ff;
      hole_in      = hole_ff;
      rd_idx_in    = rd_idx_ff;
      avail_in     = avail_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_eol_in   = rsp_eol_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      wr_en        = 1'b0;
      wr_addr      = hole_ff;
      wr_data      = val_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;

      case (state_ff)
         ST_IDLE: begin
            rd_idx_in = '0;
            avail_in  = 1'b0;
            if (req_valid) begin
               val_in  = req_value;
               last_in = req_last;
               if (fill_ff == MAX_CNT) begin
                  // drop the word
                  ovf_in = 1'b1;
                  if (req_last) state_in = ST_EMIT;
               end else if (fill_ff == '0) begin
                  wr_en   = 1'b1;
                  wr_addr = '0;
                  wr_data = req_value;
                  fill_in = CW'(1);
                  if (req_last) state_in = ST_EMIT;
               end else begin
                  hole_in  = fill_ff[AW-1:0];
                  rd_en    = 1'b1;
                  rd_addr  = AW'(fill_ff - CW'(1));
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            if (rd_data_ff > val_ff) begin
               // move the entry up into the hole and fetch the one below, if any
               wr_en   = 1'b1;
               wr_data = rd_data_ff;
               hole_in = hole_ff - AW'(1);
               if (hole_ff == AW'(1)) begin
                  state_in = ST_PLACE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = hole_ff - AW'(2);
               end
            end else begin
               wr_en    = 1'b1;
               fill_in  = fill_ff + CW'(1);
               state_in = last_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            fill_in  = fill_ff + CW'(1);
            state_in = last_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (issue) begin
               rd_en     = 1'b1;
               rd_addr   = rd_idx_ff[AW-1:0];
               rd_idx_in = rd_idx_ff + CW'(1);
               avail_in  = 1'b1;
            end else if (load) begin
               avail_in = 1'b0;
            end
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rd_data_ff;
               rsp_eol_in   = (rd_idx_ff == fill_ff);
               rsp_ovf_in   = ovf_ff;
               if (rd_idx_ff == fill_ff) begin
                  fill_in  = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_IDLE;
               end
            end else if (rsp_ready) begin
               rsp_valid_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (state_ff != ST_EMIT && rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         rd_idx_ff    <= '0;
         avail_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         rd_idx_ff    <= rd_idx_in;
         avail_ff     <= avail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff       <= val_in;
      last_ff      <= last_in;
      hole_ff      <= hole_in;
      rsp_value_ff <= rsp_value_in;
      rsp_eol_ff   <= rsp_eol_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // sorted store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) store_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= store_ff[rd_addr];
   end

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= MAX_CNT)
      else $error("fill count beyond capacity");

   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("store read and write hit the same entry");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (fill_ff != '0))
      else $error("emission with an empty list");

   a_eol_ends_list: assert property (@(posedge clock) disable iff (reset)
      (load && rsp_eol_in) |=> (state_ff == ST_IDLE && fill_ff == '0 && !ovf_ff))
      else $error("list not emptied after its final word");

endmodule
